@@ rtl/multilimb_residue_mod_2pow48_minus1_defines.svh @@
`ifndef MULTILIMB_RESIDUE_MOD_2POW48_MINUS1_DEFINES_SVH
`define MULTILIMB_RESIDUE_MOD_2POW48_MINUS1_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MLR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mlr assertion failed");

// next-cycle implication, checked out of reset
`define MLR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mlr assertion failed");

`endif

@@ rtl/mlr_pkg.sv @@
package mlr_pkg;

    localparam int LIMB_W = 64;
    localparam int RES_W  = 48;
    localparam int HIGH_W = LIMB_W - RES_W;
    localparam int SUM_W  = 49;
    localparam int PART_W = 51;

    localparam logic [RES_W-1:0] RES_ONES = {RES_W{1'b1}};

    localparam logic [1:0] PHASE_ZERO  = 2'd0;
    localparam logic [1:0] PHASE_ONE   = 2'd1;
    localparam logic [1:0] PHASE_TWO   = 2'd2;
    localparam logic [1:0] PHASE_SPARE = 2'd3;

    typedef struct packed {
        logic [SUM_W-1:0] sum_zero;
        logic [SUM_W-1:0] sum_one;
        logic [SUM_W-1:0] sum_two;
    } class_sums_t;

endpackage

@@ rtl/mlr_accum.sv @@
`include "multilimb_residue_mod_2pow48_minus1_defines.svh"

module mlr_accum (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [mlr_pkg::LIMB_W-1:0] s_tdata,   // limb
    input  logic                       s_tlast,   // last_limb
    output logic                       fin_valid,
    input  logic                       fin_ready,
    output mlr_pkg::class_sums_t       fin
);
    import mlr_pkg::*;

    logic              a_valid_reg, a_valid_next;
    logic [LIMB_W-1:0] a_limb_reg;
    logic              a_last_reg;
    logic              a_adv;

    class_sums_t       sums_reg, sums_next, sums_upd;
    logic [1:0]        phase_reg, phase_next, phase_adv;
    class_sums_t       fin_reg;
    logic              fin_valid_reg, fin_valid_next;

    logic [SUM_W-1:0]  acc_sel;
    logic [PART_W-1:0] raw_sum;
    logic [SUM_W-1:0]  folded;

    // a last limb needs the final stage free; other limbs never stall
    assign a_adv    = a_valid_reg && (!a_last_reg || !fin_valid_reg || fin_ready);
    assign s_tready = !a_valid_reg || a_adv;
    assign a_valid_next = s_tready ? s_tvalid : a_valid_reg;

    always_comb
    begin
        unique case (phase_reg)
            PHASE_ONE:
            begin
                acc_sel   = sums_reg.sum_one;
                phase_adv = PHASE_TWO;
            end
            PHASE_TWO:
            begin
                acc_sel   = sums_reg.sum_two;
                phase_adv = PHASE_ZERO;
            end
            default:
            begin
                acc_sel   = sums_reg.sum_zero;
                phase_adv = PHASE_ONE;
            end
        endcase
    end

    assign raw_sum = {{(PART_W-SUM_W){1'b0}}, acc_sel}
                   + {{(PART_W-RES_W){1'b0}}, a_limb_reg[RES_W-1:0]}
                   + {{(PART_W-HIGH_W){1'b0}}, a_limb_reg[LIMB_W-1:RES_W]};
    // end-around fold keeps the class sum below 2^49
    assign folded  = {1'b0, raw_sum[RES_W-1:0]}
                   + {{(SUM_W-(PART_W-RES_W)){1'b0}}, raw_sum[PART_W-1:RES_W]};

    always_comb
    begin
        sums_upd = sums_reg;
        unique case (phase_reg)
            PHASE_ONE: sums_upd.sum_one = folded;
            PHASE_TWO: sums_upd.sum_two = folded;
            default:   sums_upd.sum_zero = folded;
        endcase
    end

    always_comb
    begin
        sums_next  = sums_reg;
        phase_next = phase_reg;
        if (a_adv)
        begin
            if (a_last_reg)
            begin
                sums_next  = '0;
                phase_next = PHASE_ZERO;
            end
            else
            begin
                sums_next  = sums_upd;
                phase_next = phase_adv;
            end
        end
    end

    assign fin_valid_next = (fin_valid_reg && !fin_ready) || (a_adv && a_last_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            sums_reg      <= '0;
            phase_reg     <= PHASE_ZERO;
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            sums_reg      <= sums_next;
            phase_reg     <= phase_next;
            fin_valid_reg <= fin_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready)
        begin
            a_limb_reg <= s_tdata;
            a_last_reg <= s_tlast;
        end
        if (a_adv && a_last_reg)
        begin
            fin_reg <= sums_upd;
        end
    end

    assign fin_valid = fin_valid_reg;
    assign fin       = fin_reg;

    `MLR_ASSERT_NEXT(a_last_clears_state, a_adv && a_last_reg,
        phase_reg == PHASE_ZERO && sums_reg == '0)
    `MLR_ASSERT_NOW(a_phase_in_range, 1'b1, phase_reg != PHASE_SPARE)
    `MLR_ASSERT_NEXT(a_fin_holds, fin_valid_reg && !fin_ready,
        fin_valid_reg && $stable(fin_reg))

endmodule

@@ rtl/mlr_combine.sv @@
`include "multilimb_residue_mod_2pow48_minus1_defines.svh"

module mlr_combine (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      fin_valid,
    output logic                      fin_ready,
    input  mlr_pkg::class_sums_t      fin,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [mlr_pkg::RES_W-1:0] m_tdata    // residue
);
    import mlr_pkg::*;

    logic              c_valid_reg, c_valid_next;
    logic [PART_W-1:0] c_sum_reg, c_sum_next;
    logic              c_free;

    logic              out_valid_reg, out_valid_next;
    logic [RES_W-1:0]  out_res_reg;

    logic [SUM_W-1:0]  fold_one;
    logic [RES_W-1:0]  fold_two;
    logic [RES_W-1:0]  reduced;

    assign c_free    = !out_valid_reg || m_tready;
    assign fin_ready = !c_valid_reg || c_free;

    // class one rotates by 16, class two by 32, across the 48-bit boundary
    assign c_sum_next =
          {{(PART_W-SUM_W){1'b0}}, fin.sum_zero}
        + {{(PART_W-RES_W){1'b0}}, fin.sum_one[31:0], 16'b0}
        + {{(PART_W-17){1'b0}}, fin.sum_one[SUM_W-1:32]}
        + {{(PART_W-RES_W){1'b0}}, fin.sum_two[15:0], 32'b0}
        + {{(PART_W-33){1'b0}}, fin.sum_two[SUM_W-1:16]};

    assign c_valid_next = (c_valid_reg && !c_free) || (fin_valid && fin_ready);

    // two end-around folds, then all ones maps to zero
    assign fold_one = {1'b0, c_sum_reg[RES_W-1:0]}
                    + {{(SUM_W-(PART_W-RES_W)){1'b0}}, c_sum_reg[PART_W-1:RES_W]};
    assign fold_two = fold_one[RES_W-1:0] + {{(RES_W-1){1'b0}}, fold_one[SUM_W-1]};
    assign reduced  = (fold_two == RES_ONES) ? '0 : fold_two;

    assign out_valid_next = c_free ? c_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg   <= c_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_ready)
        begin
            c_sum_reg <= c_sum_next;
        end
        if (c_free)
        begin
            out_res_reg <= reduced;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg;

    `MLR_ASSERT_NOW(c_residue_reduced, out_valid_reg, out_res_reg != RES_ONES)
    `MLR_ASSERT_NEXT(c_sum_holds, c_valid_reg && !c_free,
        c_valid_reg && $stable(c_sum_reg))

endmodule

@@ rtl/multilimb_residue_mod_2pow48_minus1.sv @@
// the residue passes the limb, final-sum, combine and output registers before m_tvalid
// one limb per cycle unless a last limb stalls; each class sum update is one add-and-fold
// a stalled output buffers up to three residues in the pipeline before s_tready drops
// reset: rst_n asynchronous active low clears class sums, limb phase and all valid flags
module multilimb_residue_mod_2pow48_minus1 (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [mlr_pkg::LIMB_W-1:0] s_tdata,   // limb
    input  logic                       s_tlast,   // last_limb
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [mlr_pkg::RES_W-1:0]  m_tdata    // residue
);
    import mlr_pkg::*;

    logic        fin_valid;
    logic        fin_ready;
    class_sums_t fin;

    mlr_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin       (fin)
    );

    mlr_combine u_combine (
        .clk       (clk),
        .rst_n     (rst_n),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin       (fin),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

@@ sim/mlr_residue_check.sv @@
module mlr_residue_check (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [mlr_pkg::LIMB_W-1:0] s_tdata,   // limb
    input  logic                       s_tlast,   // last_limb
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [mlr_pkg::RES_W-1:0]  m_tdata,   // residue
    output int                         mismatches,
    output int                         residues_pending
);
    import mlr_pkg::*;

    localparam logic [63:0] LOW48 = {16'b0, RES_ONES};

    class_sums_t      sums;
    logic [1:0]       phase;
    logic [RES_W-1:0] residues_due[$];
    int               errs;

    // add the low 48 and high 16 bits of a limb, then fold at bit 48
    function automatic logic [SUM_W-1:0] fold_in_limb(input logic [SUM_W-1:0]  acc,
                                                      input logic [LIMB_W-1:0] limb);
        logic [PART_W-1:0] s;
        s = PART_W'(acc) + PART_W'(limb[RES_W-1:0]) + PART_W'(limb[LIMB_W-1:RES_W]);
        return SUM_W'(s[RES_W-1:0]) + SUM_W'(s[PART_W-1:RES_W]);
    endfunction

    // rotate the class sums into place and reduce fully
    function automatic logic [RES_W-1:0] combine_classes(input class_sums_t cs);
        logic [63:0] c0;
        logic [63:0] c1;
        logic [63:0] c2;
        logic [63:0] r;
        c0 = 64'(cs.sum_zero);
        c1 = 64'(cs.sum_one);
        c2 = 64'(cs.sum_two);
        r  = c0 + ((c1 << 16) & LOW48) + (c1 >> 32) + ((c2 << 32) & LOW48) + (c2 >> 16);
        r  = (r & LOW48) + (r >> 48);
        r  = (r & LOW48) + (r >> 48);
        if (r == LOW48)
            r = 64'd0;
        return r[RES_W-1:0];
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sums  = '0;
            phase = PHASE_ZERO;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                case (phase)
                    PHASE_ONE:
                    begin
                        sums.sum_one = fold_in_limb(sums.sum_one, s_tdata);
                        phase        = PHASE_TWO;
                    end
                    PHASE_TWO:
                    begin
                        sums.sum_two = fold_in_limb(sums.sum_two, s_tdata);
                        phase        = PHASE_ZERO;
                    end
                    default:
                    begin
                        sums.sum_zero = fold_in_limb(sums.sum_zero, s_tdata);
                        phase         = PHASE_ONE;
                    end
                endcase
                if (s_tlast)
                begin
                    residues_due.push_back(combine_classes(sums));
                    sums  = '0;
                    phase = PHASE_ZERO;
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (residues_due.size() == 0)
                begin
                    $error("residue transfer %h with no expectation waiting", m_tdata);
                    errs++;
                end
                else
                begin
                    if (m_tdata !== residues_due[0])
                    begin
                        $error("residue mismatch: expected %h, actual %h",
                               residues_due[0], m_tdata);
                        errs++;
                    end
                    void'(residues_due.pop_front());
                end
            end
        end
        mismatches       <= errs;
        residues_pending <= residues_due.size();
    end

endmodule

@@ sim/tb_multilimb_residue_mod_2pow48_minus1.sv @@
module tb_multilimb_residue_mod_2pow48_minus1;
    import mlr_pkg::*;

    localparam int         RANDOM_LIMBS = 2000;
    localparam int         HOLD_CYCLES  = 300;
    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ONES48      = {16'b0, RES_ONES};

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [LIMB_W-1:0] s_tdata  = '0;   // limb
    logic              s_tlast  = 1'b0; // last_limb
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [RES_W-1:0]  m_tdata;         // residue

    int mismatches;
    int residues_pending;
    int send_idle_pct = 20;
    int recv_idle_pct = 65;
    bit hold_req      = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    multilimb_residue_mod_2pow48_minus1 u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mlr_residue_check u_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tlast          (s_tlast),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .mismatches       (mismatches),
        .residues_pending (residues_pending)
    );

    // returns right after the edge at which the limb transfer happened
    task automatic send_limb(input logic [LIMB_W-1:0] limb, input logic is_final);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= limb;
        s_tlast  <= is_final;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    function automatic logic [LIMB_W-1:0] pick_limb();
        case ($urandom_range(9))
            0:       return ALL_ONES;
            1:       return '0;
            2:       return ONES48;
            3:       return {16'hFFFF, 48'(0)};
            4:       return ONES48 - 64'(1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // receiver side: random back-pressure plus one long hold-off on request
    initial
    begin : rx_side
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin : tx_side
        int limbs_sent;
        int limb_count;
        int pick;
        int settle;
        limbs_sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed numbers
        send_limb('0, 1'b1);
        send_limb(ALL_ONES, 1'b1);
        send_limb(ONES48, 1'b1);              // congruent to zero, must come out as 0
        send_limb(ONES48 - 64'(1), 1'b1);
        repeat (2) send_limb(ALL_ONES, 1'b0);
        send_limb(ALL_ONES, 1'b1);
        send_limb(64'd1, 1'b0);
        send_limb(64'd2, 1'b0);
        send_limb(64'd3, 1'b0);
        send_limb(64'd4, 1'b1);               // phase wraps back to class zero
        // combined sum lands exactly on 2^48-1
        send_limb(ONES48 - 64'h1_0000, 1'b0);
        send_limb(64'd1, 1'b1);
        send_limb(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_limb(64'h5555_5555_5555_5555, 1'b1);
        repeat (5) send_limb(ALL_ONES, 1'b0);
        send_limb(ALL_ONES, 1'b1);

        // receiver stalls for a long stretch while short numbers keep coming
        hold_req = 1'b1;
        while (limbs_sent < RANDOM_LIMBS)
        begin
            case (limbs_sent * 3 / RANDOM_LIMBS)
                0:
                begin
                    send_idle_pct = 20;
                    recv_idle_pct = 65;
                end
                1:
                begin
                    send_idle_pct = 65;
                    recv_idle_pct = 20;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            pick = $urandom_range(9);
            if (pick < 6)
                limb_count = $urandom_range(4, 1);
            else if (pick < 9)
                limb_count = $urandom_range(12, 5);
            else
                limb_count = $urandom_range(40, 13);
            for (int k = 0; k < limb_count; k++)
                send_limb(pick_limb(), k == limb_count - 1);
            limbs_sent += limb_count;
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        @(posedge clk);

        while (residues_pending != 0)
            @(posedge clk);
        settle = 20;
        repeat (settle) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
